// File: rtl/cutr_pkg.sv
// ----------------------------------------------------------------------------
// cutr_pkg
// Shared types, byte codes and the letter table of the Cyrillic to Latin
// transliterator.
// ----------------------------------------------------------------------------
`default_nettype none

package cutr_pkg;

   // UTF-8 lead bytes of the two-byte Cyrillic letters
   localparam logic [7:0] LEAD_D0 = 8'hD0;
   localparam logic [7:0] LEAD_D1 = 8'hD1;

   // Second-byte ranges of the letter groups
   localparam logic [7:0] UPPER_LO  = 8'h90;
   localparam logic [7:0] UPPER_HI  = 8'hAF;
   localparam logic [7:0] LOWER1_LO = 8'hB0;
   localparam logic [7:0] LOWER1_HI = 8'hBF;
   localparam logic [7:0] LOWER2_LO = 8'h80;
   localparam logic [7:0] LOWER2_HI = 8'h8F;
   localparam logic [7:0] YO_UPPER  = 8'h81;
   localparam logic [7:0] YO_LOWER  = 8'h91;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;
   localparam logic [7:0] NUL           = 8'h00;

   localparam int unsigned MAX_RUN = 3;

   // Latin replacement of one letter: length and up to three characters
   typedef struct packed {
      logic [1:0]               len;
      logic [MAX_RUN-1:0][7:0]  txt;
   } latin_type;

   // Bytes caused by one input beat
   typedef struct packed {
      logic [1:0]               cnt;
      logic [MAX_RUN-1:0][7:0]  bytes;
      logic                     text_end;
   } run_type;

   function automatic latin_type mk_latin(input logic [1:0] len, input logic [7:0] c0,
                                          input logic [7:0] c1, input logic [7:0] c2);
      latin_type r;
      r.len    = len;
      r.txt[0] = c0;
      r.txt[1] = c1;
      r.txt[2] = c2;
      return r;
   endfunction

   // Upper-case replacement for U+0410..U+042F in code order
   function automatic latin_type upper_latin(input logic [4:0] idx);
      latin_type r;
      unique case (idx)
         5'd0:    r = mk_latin(2'd1, "A",  NUL, NUL);
         5'd1:    r = mk_latin(2'd1, "B",  NUL, NUL);
         5'd2:    r = mk_latin(2'd1, "V",  NUL, NUL);
         5'd3:    r = mk_latin(2'd1, "G",  NUL, NUL);
         5'd4:    r = mk_latin(2'd1, "D",  NUL, NUL);
         5'd5:    r = mk_latin(2'd1, "E",  NUL, NUL);
         5'd6:    r = mk_latin(2'd2, "Z",  "h", NUL);
         5'd7:    r = mk_latin(2'd1, "Z",  NUL, NUL);
         5'd8:    r = mk_latin(2'd1, "I",  NUL, NUL);
         5'd9:    r = mk_latin(2'd1, "J",  NUL, NUL);
         5'd10:   r = mk_latin(2'd1, "K",  NUL, NUL);
         5'd11:   r = mk_latin(2'd1, "L",  NUL, NUL);
         5'd12:   r = mk_latin(2'd1, "M",  NUL, NUL);
         5'd13:   r = mk_latin(2'd1, "N",  NUL, NUL);
         5'd14:   r = mk_latin(2'd1, "O",  NUL, NUL);
         5'd15:   r = mk_latin(2'd1, "P",  NUL, NUL);
         5'd16:   r = mk_latin(2'd1, "R",  NUL, NUL);
         5'd17:   r = mk_latin(2'd1, "S",  NUL, NUL);
         5'd18:   r = mk_latin(2'd1, "T",  NUL, NUL);
         5'd19:   r = mk_latin(2'd1, "U",  NUL, NUL);
         5'd20:   r = mk_latin(2'd1, "F",  NUL, NUL);
         5'd21:   r = mk_latin(2'd1, "H",  NUL, NUL);
         5'd22:   r = mk_latin(2'd2, "T",  "s", NUL);
         5'd23:   r = mk_latin(2'd2, "C",  "h", NUL);
         5'd24:   r = mk_latin(2'd2, "S",  "h", NUL);
         5'd25:   r = mk_latin(2'd3, "S",  "h", "h");
         5'd26:   r = mk_latin(2'd0, NUL,  NUL, NUL);
         5'd27:   r = mk_latin(2'd1, "Y",  NUL, NUL);
         5'd28:   r = mk_latin(2'd1, "'",  NUL, NUL);
         5'd29:   r = mk_latin(2'd1, "E",  NUL, NUL);
         5'd30:   r = mk_latin(2'd2, "Y",  "u", NUL);
         5'd31:   r = mk_latin(2'd2, "Y",  "a", NUL);
         default: r = mk_latin(2'd0, NUL,  NUL, NUL);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cutr_req_if.sv
// ----------------------------------------------------------------------------
// cutr_req_if
// Input channel: one raw UTF-8 byte and the end-of-text flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cutr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       text_end;

   modport source (output valid, output in_byte, output text_end, input ready);
   modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

`default_nettype wire

// File: rtl/cutr_rsp_if.sv
// ----------------------------------------------------------------------------
// cutr_rsp_if
// Result channel: one output byte with its run and text markers per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cutr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       output_end;

   modport source (output valid, output out_byte, output run_last, output output_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input output_end,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/cyrillic_utf8_transliterator_unit.sv
// ----------------------------------------------------------------------------
// cyrillic_utf8_transliterator_unit
// Replaces two-byte Cyrillic letters of a UTF-8 stream by Latin text and
// passes every other byte through unchanged.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      beat contents
//  req_ch    in    valid/ready    in_byte, text_end
//  rsp_ch    out   valid/ready    out_byte, run_last, output_end
//
//  An input byte waits in the input register, is matched against
//  the pending byte and expands into a run of 0 to 3 result bytes.
//  The single output byte register sends one beat per cycle while the
//  receiver is ready; a new beat can enter every cycle while runs are short.
//  On its way to the result a byte passes the input, run and output registers.
//  Synchronous reset empties all stages and clears the pending byte.
//  A stalled result holds the run register, which then stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module cyrillic_utf8_transliterator_unit
   import cutr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cutr_req_if.sink   req_ch,
   cutr_rsp_if.source rsp_ch
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       held_valid_ff;
   logic       held_valid_in;
   logic [7:0] held_byte_ff;
   logic [7:0] held_byte_in;
   logic       run_ready;
   logic       in_take;
   logic       req_take;
   run_type    dec_run;

   // Advance the input register when the run register can take its run
   assign in_take       = in_valid_ff && run_ready;
   assign req_ch.ready  = !in_valid_ff || run_ready;
   assign req_take      = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.in_byte;
         in_end_ff  <= req_ch.text_end;
      end
   end

   // Match against the pending byte
   cutr_decode u_decode (
      .held_valid      (held_valid_ff),
      .held_byte       (held_byte_ff),
      .in_byte         (in_byte_ff),
      .text_end        (in_end_ff),
      .run             (dec_run),
      .held_valid_next (held_valid_in),
      .held_byte_next  (held_byte_in)
   );

   // Update the pending byte as each beat is decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'h00;
      end else if (in_take) begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
      end
   end

   cutr_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .run_load  (in_take),
      .run_new   (dec_run),
      .run_ready (run_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// File: rtl/cutr_decode.sv
// ----------------------------------------------------------------------------
// cutr_decode
// Pair matcher: forms the output run of one input byte from the pending byte
// and computes the next pending state.
// ----------------------------------------------------------------------------
`default_nettype none

module cutr_decode
   import cutr_pkg::*;
(
   input  logic       held_valid,
   input  logic [7:0] held_byte,
   input  logic [7:0] in_byte,
   input  logic       text_end,
   output run_type    run,
   output logic       held_valid_next,
   output logic [7:0] held_byte_next
);

   latin_type rep;
   logic      hit;
   logic      lower;

   // Match the pending byte and the new byte against the letter codes
   always_comb begin
      rep   = upper_latin(5'd0);
      hit   = 1'b0;
      lower = 1'b0;
      if (held_byte == LEAD_D0 && in_byte >= UPPER_LO && in_byte <= UPPER_HI) begin
         rep = upper_latin(5'(in_byte - UPPER_LO));
         hit = 1'b1;
      end else if (held_byte == LEAD_D0 && in_byte >= LOWER1_LO && in_byte <= LOWER1_HI) begin
         rep   = upper_latin({1'b0, in_byte[3:0]});
         hit   = 1'b1;
         lower = 1'b1;
      end else if (held_byte == LEAD_D1 && in_byte >= LOWER2_LO && in_byte <= LOWER2_HI) begin
         rep   = upper_latin({1'b1, in_byte[3:0]});
         hit   = 1'b1;
         lower = 1'b1;
      end else if (held_byte == LEAD_D0 && in_byte == YO_UPPER) begin
         rep = mk_latin(2'd2, "Y", "o", NUL);
         hit = 1'b1;
      end else if (held_byte == LEAD_D1 && in_byte == YO_LOWER) begin
         rep = mk_latin(2'd2, "y", "o", NUL);
         hit = 1'b1;
      end
      // lower the first letter of a lower-case replacement
      if (lower && rep.len != 2'd0 && rep.txt[0] >= ASCII_UPPER_A
          && rep.txt[0] <= ASCII_UPPER_Z) begin
         rep.txt[0] = rep.txt[0] + CASE_OFFSET;
      end
   end

   // Build the run and the next pending state
   always_comb begin
      run.cnt      = 2'd0;
      run.bytes    = '0;
      run.text_end = text_end;
      held_valid_next = 1'b0;
      held_byte_next  = 8'h00;
      if (held_valid && hit) begin
         run.cnt   = rep.len;
         run.bytes = rep.txt;
      end else begin
         if (held_valid) begin
            run.bytes[0] = held_byte;
            run.cnt      = 2'd1;
         end
         if (text_end) begin
            if (held_valid) begin
               run.bytes[1] = in_byte;
               run.cnt      = 2'd2;
            end else begin
               run.bytes[0] = in_byte;
               run.cnt      = 2'd1;
            end
         end else begin
            held_valid_next = 1'b1;
            held_byte_next  = in_byte;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/cutr_serializer.sv
// ----------------------------------------------------------------------------
// cutr_serializer
// Run register and output byte register: sends a run of up to three bytes
// one beat per cycle while the receiver is ready, and marks the last byte of each run.
// ----------------------------------------------------------------------------
`default_nettype none

module cutr_serializer
   import cutr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          run_load,
   input  run_type       run_new,
   output logic          run_ready,
   cutr_rsp_if.source    rsp_ch
);

   run_type    run_ff;
   run_type    run_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_end_ff;
   logic       out_load;

   // Move one byte to the output register when it is empty or draining
   assign out_load  = (run_ff.cnt != 2'd0) && (!out_valid_ff || rsp_ch.ready);
   assign run_ready = (run_ff.cnt == 2'd0) || (run_ff.cnt == 2'd1 && out_load);

   // Shift the run down, or take a fresh run
   always_comb begin
      run_in = run_ff;
      if (out_load) begin
         run_in.bytes[0] = run_ff.bytes[1];
         run_in.bytes[1] = run_ff.bytes[2];
         run_in.cnt      = run_ff.cnt - 2'd1;
      end
      if (run_load) begin
         run_in = run_new;
      end
   end

   // Hold the output beat until it is taken
   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff <= run_ff.bytes[0];
         out_last_ff <= (run_ff.cnt == 2'd1);
         out_end_ff  <= (run_ff.cnt == 2'd1) && run_ff.text_end;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.run_last   = out_last_ff;
   assign rsp_ch.output_end = out_end_ff;

endmodule

`default_nettype wire

// File: rtl/cutr_checker.sv
// ----------------------------------------------------------------------------
// cutr_checker
// Port-level checks of the transliterator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cutr_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_out_byte,
   input wire       rsp_run_last,
   input wire       rsp_output_end
);

   // End of text is always the last byte of its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_output_end |-> rsp_run_last)
      else $error("output_end without run_last");

   // Reset empties the output stage
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled beat keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
      && $stable(rsp_run_last) && $stable(rsp_output_end))
      else $error("stalled result beat changed");

endmodule

bind cyrillic_utf8_transliterator_unit cutr_checker u_cutr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_byte   (rsp_ch.out_byte),
   .rsp_run_last   (rsp_ch.run_last),
   .rsp_output_end (rsp_ch.output_end)
);

`default_nettype wire
